// ===== rtl/cusf_pkg.sv =====
package cusf_pkg;

  localparam int unsigned MAX_PEOPLE = 64;
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EL_PRIME,
    S_EL_HEAD,
    S_EL_STEP,
    S_VER,
    S_VER_LAST,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic wr;
    logic el_prime;
    logic el_head;
    logic el_step;
    logic ver_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic k_one;
    logic i_last;
    logic out_free;
  } status_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n < CNT_W'(2)) r = CNT_W'(2);
    if (n > CNT_W'(MAX_PEOPLE)) r = CNT_W'(MAX_PEOPLE);
    return r;
  endfunction

endpackage

// ===== rtl/cusf_in_if.sv =====
interface cusf_in_if;
  logic                        valid;
  logic                        ready;
  logic [cusf_pkg::ROW_W-1:0]  row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

// ===== rtl/cusf_out_if.sv =====
interface cusf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [cusf_pkg::IDX_W-1:0]  celebrity_index;

  modport source (output valid, output found, output celebrity_index, input ready);
  modport sink   (input valid, input found, input celebrity_index, output ready);
endinterface

// ===== rtl/cusf_ctrl.sv =====
module cusf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cusf_pkg::status_t sts,
  output cusf_pkg::cmd_t    cmd
);

  cusf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cusf_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cusf_pkg::S_LOAD: begin
        if (in_valid && sts.complete) state_nxt = cusf_pkg::S_EL_PRIME;
      end
      cusf_pkg::S_EL_PRIME: state_nxt = cusf_pkg::S_EL_HEAD;
      cusf_pkg::S_EL_HEAD:  state_nxt = cusf_pkg::S_EL_STEP;
      cusf_pkg::S_EL_STEP: begin
        if (sts.k_one) state_nxt = cusf_pkg::S_VER;
      end
      cusf_pkg::S_VER: begin
        if (sts.i_last) state_nxt = cusf_pkg::S_VER_LAST;
      end
      cusf_pkg::S_VER_LAST: state_nxt = cusf_pkg::S_FINISH;
      cusf_pkg::S_FINISH: begin
        if (sts.out_free) state_nxt = cusf_pkg::S_LOAD;
      end
      default: state_nxt = cusf_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      cusf_pkg::S_LOAD: begin
        in_ready = 1'b1;
        cmd.wr   = in_valid;
      end
      cusf_pkg::S_EL_PRIME: cmd.el_prime = 1'b1;
      cusf_pkg::S_EL_HEAD:  cmd.el_head  = 1'b1;
      cusf_pkg::S_EL_STEP:  cmd.el_step  = 1'b1;
      cusf_pkg::S_VER:      cmd.ver_rd   = 1'b1;
      cusf_pkg::S_VER_LAST: cmd          = '0;
      cusf_pkg::S_FINISH:   cmd.finish   = 1'b1;
      default:              cmd          = '0;
    endcase
  end

endmodule

// ===== rtl/cusf_dp.sv =====
module cusf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cusf_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic [cusf_pkg::ROW_W-1:0]  row_bits,
  input  cusf_pkg::cmd_t              cmd,
  output cusf_pkg::status_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [cusf_pkg::IDX_W-1:0]  out_index
);

  logic [cusf_pkg::ROW_W-1:0] mem [cusf_pkg::MAX_PEOPLE];

  logic [cusf_pkg::CNT_W-1:0] count_r;
  logic [cusf_pkg::CNT_W-1:0] n;
  logic [cusf_pkg::CNT_W-1:0] n_m1;
  logic [cusf_pkg::CNT_W-1:0] rows_loaded_r, rows_loaded_nxt;
  logic [cusf_pkg::IDX_W-1:0] cand_r, k_r, i_r;
  logic [cusf_pkg::IDX_W-1:0] rd_addr;
  logic [cusf_pkg::ROW_W-1:0] rd_data_r, cand_row_r, mask;
  logic [cusf_pkg::CNT_W-1:0] ones_r;
  logic                       rdv_r;
  logic                       ok;
  logic                       out_valid_r, found_r;
  logic [cusf_pkg::IDX_W-1:0] index_r;
  logic                       load_out;

  assign n    = cusf_pkg::eff_count(count_r);
  assign n_m1 = n - cusf_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= cusf_pkg::CNT_W'(2);
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // row loading
  assign rows_loaded_nxt = rows_loaded_r + cusf_pkg::CNT_W'(1);
  assign sts.complete    = (rows_loaded_nxt >= n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r <= '0;
    end else if (cmd.wr) begin
      rows_loaded_r <= sts.complete ? '0 : rows_loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && !rows_loaded_r[cusf_pkg::CNT_W-1]) begin
      mem[rows_loaded_r[cusf_pkg::IDX_W-1:0]] <= row_bits;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.el_prime)     rd_addr = n_m1[cusf_pkg::IDX_W-1:0];
    else if (cmd.el_head) rd_addr = k_r - cusf_pkg::IDX_W'(1);
    else if (cmd.el_step) rd_addr = k_r - cusf_pkg::IDX_W'(2);
    else if (cmd.ver_rd)  rd_addr = i_r;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // elimination scan and column count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      k_r    <= '0;
      i_r    <= '0;
      ones_r <= '0;
      rdv_r  <= 1'b0;
    end else begin
      rdv_r <= cmd.ver_rd;
      if (cmd.el_prime) begin
        cand_r <= n_m1[cusf_pkg::IDX_W-1:0];
        k_r    <= n_m1[cusf_pkg::IDX_W-1:0];
        i_r    <= '0;
        ones_r <= '0;
      end
      if (cmd.el_step) begin
        if (cand_row_r[k_r - cusf_pkg::IDX_W'(1)]) begin
          cand_r <= k_r - cusf_pkg::IDX_W'(1);
        end
        k_r <= k_r - cusf_pkg::IDX_W'(1);
      end
      if (cmd.ver_rd) begin
        i_r <= i_r + cusf_pkg::IDX_W'(1);
      end
      if (rdv_r) begin
        ones_r <= ones_r + cusf_pkg::CNT_W'(rd_data_r[cand_r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.el_head) begin
      cand_row_r <= rd_data_r;
    end else if (cmd.el_step && cand_row_r[k_r - cusf_pkg::IDX_W'(1)]) begin
      cand_row_r <= rd_data_r;
    end
  end

  assign sts.k_one  = (k_r == cusf_pkg::IDX_W'(1));
  assign sts.i_last = ({1'b0, i_r} == n_m1);

  always_comb begin
    for (int j = 0; j < cusf_pkg::ROW_W; j++) begin
      mask[j] = (cusf_pkg::CNT_W'(j) < n);
    end
  end

  assign ok = ((cand_row_r & mask) == '0) && (ones_r == n_m1);

  // result register
  assign sts.out_free = !out_valid_r || out_ready;
  assign load_out     = cmd.finish && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found_r <= ok;
      index_r <= ok ? cand_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = found_r;
  assign out_index = index_r;

endmodule

// ===== rtl/celebrity_universal_sink_finder_top.sv =====
// Celebrity finder. Rows of an n x n "knows" matrix arrive one per word,
// row 0 first; n is cfg_wdata (clamped to 2..64, reset 2). Row words are
// taken only in the load state. After row n-1 the block reads the row store
// back over a single read port for the candidate scan, then for the column
// check, and then posts the result; no row is taken in that time, nor while
// it waits for the previous result word to be taken. One result word per
// matrix: found, plus the index (0 when none).
// The result sits in an output register, so loading of the next matrix
// proceeds while it waits to be taken.
module celebrity_universal_sink_finder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  cusf_in_if.sink                     in_word,
  cusf_out_if.source                  out_word,
  input  logic                        cfg_we,
  input  logic [cusf_pkg::CNT_W-1:0]  cfg_wdata
);

  cusf_pkg::cmd_t    cmd;
  cusf_pkg::status_t sts;

  cusf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cusf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .row_bits  (in_word.row_bits),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .out_found (out_word.found),
    .out_index (out_word.celebrity_index)
  );

endmodule

// ===== rtl/cusf_chk.sv =====
module cusf_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [cusf_pkg::IDX_W-1:0]  out_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_index))
    else $error("result word changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_index == '0)
    else $error("index nonzero with no celebrity");

  a_post_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result posted while taking rows");

  a_busy_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |=> !in_ready ##1 !in_ready)
    else $error("row port reopened too early after a matrix");

endmodule

bind celebrity_universal_sink_finder_top cusf_chk u_cusf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_found (out_word.found),
  .out_index (out_word.celebrity_index)
);
